// ----- rtl/register_alu_executor_with_flags_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the register ALU executor
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef REGISTER_ALU_EXECUTOR_WITH_FLAGS_MACROS_SVH
`define REGISTER_ALU_EXECUTOR_WITH_FLAGS_MACROS_SVH
`ifndef ASSERT_OFF
`define RAE_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error("assertion failed");
`else
`define RAE_ASSERT_IMPL(label, clk, rst_n, prop)
`define RAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rae_pkg.sv -----
// ----------------------------------------------------------------------------
// Register ALU executor package
// Shared types, opcodes and sizes for the executor modules.
// ----------------------------------------------------------------------------
package rae_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_W    = 32;
    localparam int IDX_W    = 5;
    localparam int Q_DEPTH  = 2;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_AND   = 4'd2,
        OP_XOR   = 4'd3,
        OP_OR    = 4'd4,
        OP_ADDI  = 4'd5,
        OP_SUBI  = 4'd6,
        OP_ANDI  = 4'd7,
        OP_XORI  = 4'd8,
        OP_ORI   = 4'd9,
        OP_MOVR  = 4'd10,
        OP_MOVI  = 4'd11,
        OP_SWP   = 4'd12,
        OP_INPUT = 4'd13,
        OP_OUTPUT = 4'd14,
        OP_EXIT  = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_AND = 3'd2,
        FN_XOR = 3'd3,
        FN_OR  = 3'd4
    } t_fn;

    typedef struct packed {
        logic [3:0]        kind;
        logic [IDX_W-1:0]  dest_index;
        logic [IDX_W-1:0]  src_a_index;
        logic [IDX_W-1:0]  src_b_index;
        logic signed [REG_W-1:0] immediate;
    } t_in;

    typedef struct packed {
        logic signed [REG_W-1:0] value;
        logic parity_flag;
        logic zero_flag;
        logic sign_flag;
        logic overflow_flag;
    } t_out;

    // Classified request that travels from the front part to the back part.
    typedef struct packed {
        logic             is_alu;
        t_fn              fn;
        logic             b_imm;
        logic             ovf_add;
        logic             ovf_sub;
        logic             ovf_clr;
        logic             wr_dest;
        logic             val_a;
        logic             val_imm;
        logic             val_r0;
        logic             is_swp;
        logic             is_input;
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] sa;
        logic [IDX_W-1:0] sb;
        logic [REG_W-1:0] imm;
    } t_dec;

endpackage

// ----- rtl/register_alu_executor_with_flags.sv -----
// ----------------------------------------------------------------------------
// Register ALU executor with status flags
// Executes decoded instructions on a 32 x 32-bit register file.
// ----------------------------------------------------------------------------
// One instruction a cycle is sustained while the result queue has room: an
// accepted request is registered in the two-entry decode queue, then the back
// part reads the register file, runs the ALU, writes back and loads the
// two-entry result queue together, so a result reaches the outputs through
// the decode queue and then the result queue. A full result queue stalls the
// back part, and the decode queue then fills and raises full.
// Each instruction gives exactly one result carrying the flags after it.
`include "register_alu_executor_with_flags_macros.svh"
module register_alu_executor_with_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  rae_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output rae_pkg::t_out o_out
);

    logic          w_valid, w_take;
    rae_pkg::t_dec w_dec;
    logic          w_zero_ok;

    rae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_in    (i_in),
        .o_full  (full),
        .o_valid (w_valid),
        .o_dec   (w_dec),
        .i_take  (w_take)
    );

    rae_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_dec   (w_dec),
        .o_take  (w_take),
        .o_empty (empty),
        .o_out   (o_out),
        .i_pop   (pop)
    );

    // A zero result has no one bits and no sign bit.
    assign w_zero_ok = !o_out.sign_flag && !o_out.parity_flag;

    `RAE_ASSERT_NEXT(a_req_reaches_queue, i_clk, i_rst_n, push && !full, w_valid)
    `RAE_ASSERT_NEXT(a_exec_makes_result, i_clk, i_rst_n, w_valid && w_take, !empty)
    `RAE_ASSERT_IMPL(a_zero_flag_sane, i_clk, i_rst_n, !empty && o_out.zero_flag |-> w_zero_ok)

endmodule

// ----- rtl/rae_front.sv -----
// ----------------------------------------------------------------------------
// Front part: decode and request queue
// Classifies each instruction and holds it in a short queue for the back part.
// ----------------------------------------------------------------------------
module rae_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rae_pkg::t_in   i_in,
    output logic           o_full,
    output logic           o_valid,
    output rae_pkg::t_dec  o_dec,
    input  logic           i_take
);

    rae_pkg::t_dec r_q [rae_pkg::Q_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp, n_rp;
    logic [1:0]    n_cnt;
    rae_pkg::t_dec w_dec;
    rae_pkg::t_op  w_op;
    logic          w_wr, w_rd;

    always_comb begin
        w_op            = rae_pkg::t_op'(i_in.kind);
        w_dec           = '0;
        w_dec.d         = i_in.dest_index;
        w_dec.sa        = i_in.src_a_index;
        w_dec.sb        = i_in.src_b_index;
        w_dec.imm       = i_in.immediate;
        w_dec.is_alu    = (i_in.kind <= rae_pkg::OP_ORI);
        w_dec.b_imm     = (i_in.kind >= rae_pkg::OP_ADDI);
        unique case (w_op)
            rae_pkg::OP_ADD, rae_pkg::OP_ADDI: w_dec.fn = rae_pkg::FN_ADD;
            rae_pkg::OP_SUB, rae_pkg::OP_SUBI: w_dec.fn = rae_pkg::FN_SUB;
            rae_pkg::OP_AND, rae_pkg::OP_ANDI: w_dec.fn = rae_pkg::FN_AND;
            rae_pkg::OP_XOR, rae_pkg::OP_XORI: w_dec.fn = rae_pkg::FN_XOR;
            default:                           w_dec.fn = rae_pkg::FN_OR;
        endcase
        w_dec.ovf_add   = (w_op == rae_pkg::OP_ADD);
        w_dec.ovf_sub   = (w_op == rae_pkg::OP_SUB) || (w_op == rae_pkg::OP_SUBI);
        w_dec.ovf_clr   = (w_op == rae_pkg::OP_ANDI);
        w_dec.val_a     = (w_op == rae_pkg::OP_MOVR);
        w_dec.val_imm   = (w_op == rae_pkg::OP_MOVI) || (w_op == rae_pkg::OP_INPUT);
        w_dec.val_r0    = (w_op == rae_pkg::OP_OUTPUT);
        w_dec.is_swp    = (w_op == rae_pkg::OP_SWP);
        w_dec.is_input  = (w_op == rae_pkg::OP_INPUT);
        w_dec.wr_dest   = w_dec.is_alu || w_dec.val_a || (w_op == rae_pkg::OP_MOVI);
    end

    assign o_full  = (r_cnt == 2'(rae_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_dec   = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_dec;
        end
    end

endmodule

// ----- rtl/rae_back.sv -----
// ----------------------------------------------------------------------------
// Back part: register file, ALU, flags and result queue
// Executes one queued request per cycle, while the two-entry result queue has room.
// ----------------------------------------------------------------------------
module rae_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rae_pkg::t_dec  i_dec,
    output logic           o_take,
    output logic           o_empty,
    output rae_pkg::t_out  o_out,
    input  logic           i_pop
);

    logic [rae_pkg::REG_W-1:0] r_rf [rae_pkg::NUM_REGS];
    logic [3:0]                r_flags;
    rae_pkg::t_out             r_oq [2];
    logic                      r_wp, r_rp;
    logic [1:0]                r_cnt;
    logic [3:0]                n_flags;
    logic [rae_pkg::REG_W-1:0] w_a, w_b, w_d, w_r, w_val;
    logic                      w_go, w_rd, w_ovf;
    rae_pkg::t_out             w_out;

    assign o_take  = (r_cnt != 2'd2);
    assign w_go    = i_valid && o_take;
    assign o_empty = (r_cnt == 2'd0);
    assign o_out   = r_oq[r_rp];
    assign w_rd    = i_pop && !o_empty;

    assign w_a = r_rf[i_dec.sa];
    assign w_d = r_rf[i_dec.d];
    assign w_b = i_dec.b_imm ? i_dec.imm : r_rf[i_dec.sb];

    always_comb begin
        unique case (i_dec.fn)
            rae_pkg::FN_ADD: w_r = w_a + w_b;
            rae_pkg::FN_SUB: w_r = w_a - w_b;
            rae_pkg::FN_AND: w_r = w_a & w_b;
            rae_pkg::FN_XOR: w_r = w_a ^ w_b;
            default:         w_r = w_a | w_b;
        endcase
        w_ovf   = 1'b0;
        n_flags = r_flags;
        if (i_dec.is_alu) begin
            n_flags[0] = ^w_r;
            n_flags[1] = (w_r == '0);
            n_flags[2] = w_r[rae_pkg::REG_W-1];
            if (i_dec.ovf_add) begin
                w_ovf      = (w_a[31] ^ w_r[31]) & (w_b[31] ^ w_r[31]);
                n_flags[3] = w_ovf;
            end else if (i_dec.ovf_sub) begin
                w_ovf      = (w_a[31] ^ w_b[31]) & (w_a[31] ^ w_r[31]);
                n_flags[3] = w_ovf;
            end else if (i_dec.ovf_clr) begin
                n_flags[3] = 1'b0;
            end
        end
        // Swap reports the old source value, which lands in the destination.
        priority if (i_dec.is_alu) begin
            w_val = w_r;
        end else if (i_dec.val_a || i_dec.is_swp) begin
            w_val = w_a;
        end else if (i_dec.val_imm) begin
            w_val = i_dec.imm;
        end else if (i_dec.val_r0) begin
            w_val = r_rf[0];
        end else begin
            w_val = '0;
        end
        w_out.value         = w_val;
        w_out.parity_flag   = n_flags[0];
        w_out.zero_flag     = n_flags[1];
        w_out.sign_flag     = n_flags[2];
        w_out.overflow_flag = n_flags[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rae_pkg::NUM_REGS; k++) begin
                r_rf[k] <= '0;
            end
            r_flags <= 4'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (w_go) begin
                r_flags <= n_flags;
                if (i_dec.wr_dest) begin
                    r_rf[i_dec.d] <= w_val;
                end else if (i_dec.is_input) begin
                    r_rf[0] <= i_dec.imm;
                end else if (i_dec.is_swp) begin
                    r_rf[i_dec.d]  <= w_a;
                    r_rf[i_dec.sa] <= w_d;
                end
            end
            if (w_go) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_go} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_oq[r_wp] <= w_out;
        end
    end

endmodule
